### hw/rtl/fgsa_pkg.sv
// Shared constants, lane control struct and the binary16 fused multiply-add.
`default_nettype none
package fgsa_pkg;

    localparam int LANES     = 4;
    localparam int NUM_LANES = 4;
    localparam int FP_W      = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 82;

    localparam logic [FP_W-1:0] QNAN16    = 16'h7E00;
    localparam logic [FP_W-1:0] ALPHA_RST = 16'h3C00;
    localparam logic [FP_W-1:0] NEG_ZERO  = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA = 2'd0,
        REG_BETA  = 2'd1,
        REG_INNER = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic acc_we;
        logic first;
        logic s1_load;
        logic s2_load;
        logic s2_scale_only;
    } lane_ctl_t;

    // Significand and shift that places its lsb on a 2^-48 grid.
    function automatic logic [10:0] fp_sig(input logic [FP_W-1:0] h);
        fp_sig = (h[14:10] == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
    endfunction

    function automatic logic [5:0] fp_shift(input logic [FP_W-1:0] h);
        fp_shift = (h[14:10] == 5'd0) ? 6'd24 : (6'({1'b0, h[14:10]}) + 6'd23);
    endfunction

    // Round mag * 2^-48 (mag nonzero) to binary16, nearest even.
    function automatic logic [FP_W-1:0] round_pack(input logic s, input logic [SUM_W-1:0] mag);
        int          len;
        int          q;
        int          sh;
        logic [SUM_W-1:0] sig;
        logic [SUM_W-1:0] mask;
        logic        rbit;
        logic        sticky;
        logic [FP_W-1:0] res;
        len = 0;
        for (int i = 0; i < SUM_W; i++) begin
            if (mag[i]) len = i + 1;
        end
        if (len >= 35) begin
            q  = len - 59;
            sh = len - 11;
        end else begin
            q  = -24;
            sh = 24;
        end
        sig    = mag >> sh;
        rbit   = mag[sh-1];
        mask   = (SUM_W'(1) << (sh - 1)) - SUM_W'(1);
        sticky = |(mag & mask);
        if (rbit && (sticky || sig[0])) sig = sig + SUM_W'(1);
        if (sig == SUM_W'(2048)) begin
            sig = SUM_W'(1024);
            q   = q + 1;
        end
        if (sig < SUM_W'(1024)) begin
            res = {s, 5'd0, sig[9:0]};
        end else if (q + 25 >= 31) begin
            res = {s, 15'h7C00};
        end else begin
            res = {s, 5'(q + 25), sig[9:0]};
        end
        return res;
    endfunction

    // x*y + z with a single rounding; exact sum on a fixed 2^-48 grid.
    function automatic logic [FP_W-1:0] fp16_fma(input logic [FP_W-1:0] x,
                                                 input logic [FP_W-1:0] y,
                                                 input logic [FP_W-1:0] z);
        logic ps;
        logic xnan, ynan, znan, xinf, yinf, zinf, xzero, yzero;
        logic [21:0] p;
        logic [10:0] c;
        logic [SUM_W-1:0] pw;
        logic [SUM_W-1:0] cw;
        logic [6:0] psh;
        logic [FP_W-1:0] res;
        ps    = x[15] ^ y[15];
        xnan  = x[14:0] > 15'h7C00;
        ynan  = y[14:0] > 15'h7C00;
        znan  = z[14:0] > 15'h7C00;
        xinf  = x[14:0] == 15'h7C00;
        yinf  = y[14:0] == 15'h7C00;
        zinf  = z[14:0] == 15'h7C00;
        xzero = x[14:0] == 15'd0;
        yzero = y[14:0] == 15'd0;
        p     = 22'(fp_sig(x)) * 22'(fp_sig(y));
        c     = fp_sig(z);
        psh   = 7'(fp_shift(x)) + 7'(fp_shift(y)) - 7'd48;
        pw    = SUM_W'(p) << psh;
        cw    = SUM_W'(c) << fp_shift(z);
        if (xnan || ynan || znan) begin
            res = QNAN16;
        end else if ((xinf && yzero) || (yinf && xzero)) begin
            res = QNAN16;
        end else if (xinf || yinf) begin
            res = (zinf && (z[15] != ps)) ? QNAN16 : {ps, 15'h7C00};
        end else if (zinf) begin
            res = z;
        end else if (p == 22'd0 && c == 11'd0) begin
            res = {ps & z[15], 15'd0};
        end else if (p == 22'd0) begin
            res = z;
        end else if (ps == z[15]) begin
            res = round_pack(ps, pw + cw);
        end else if (pw > cw) begin
            res = round_pack(ps, pw - cw);
        end else if (cw > pw) begin
            res = round_pack(z[15], cw - pw);
        end else begin
            res = 16'd0;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/fgsa_lane.sv
// One output column: fp16 accumulator, beta scaling and the final alpha fma.
`default_nettype none
module fgsa_lane (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire fgsa_pkg::lane_ctl_t    ctl,
    input  wire logic [15:0]            a_value,
    input  wire logic [15:0]            b_value,
    input  wire logic [15:0]            c_old,
    input  wire logic [15:0]            alpha_bits,
    input  wire logic [15:0]            beta_bits,
    output logic [15:0]                 c_new
);
    import fgsa_pkg::*;

    logic [FP_W-1:0] acc_reg;
    logic [FP_W-1:0] acc_next;
    logic [FP_W-1:0] s1_acc_reg;
    logic [FP_W-1:0] s1_scaled_reg;
    logic [FP_W-1:0] res_reg;
    logic [FP_W-1:0] res_next;

    // first step of an output starts from b*a, later steps fuse into the running sum
    assign acc_next = ctl.first ? fp16_fma(b_value, a_value, NEG_ZERO)
                                : fp16_fma(a_value, b_value, acc_reg);
    assign res_next = ctl.s2_scale_only ? s1_scaled_reg
                                        : fp16_fma(alpha_bits, s1_acc_reg, s1_scaled_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            s1_acc_reg    <= '0;
            s1_scaled_reg <= '0;
            res_reg       <= '0;
        end
        else
        begin
            if (ctl.acc_we)
            begin
                acc_reg <= acc_next;
            end
            if (ctl.s1_load)
            begin
                s1_acc_reg    <= acc_next;
                s1_scaled_reg <= fp16_fma(c_old, beta_bits, NEG_ZERO);
            end
            if (ctl.s2_load)
            begin
                res_reg <= res_next;
            end
        end
    end

    assign c_new = res_reg;

endmodule
`default_nettype wire

### hw/rtl/fp16_gemm_scaled_accumulate_top.sv
// Top level: stream ports, config registers, step counter and output merge.
// Usage:
//   s_* carries one request per inner step: one A element plus four B and
//   four old C values. m_* returns four updated C values once inner_len
//   steps have been taken (or for every request when inner_len is 0).
//   cfg_* writes alpha (0), beta (1) and inner_len (2); write only when idle.
// Throughput: one request per cycle while s_tready is high; each lane runs one
//   fp16 fma per cycle in its accumulator loop, which sets the rate.
// Stages: a completing request is registered in the accumulate/scale stage,
//   then in the alpha fma stage, whose register drives m_*.
// Reset: alpha = 1.0, beta = 0, inner_len = 1, step counter cleared, no
//   result pending.
// Stall: with m_tready low the output holds; one more result waits in the
//   middle stage, then s_tready drops until the output drains.
`default_nettype none
module fp16_gemm_scaled_accumulate_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_value, b_lane0..3, c_old_lane0..3 (16 bits each, lowest first)
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // c_new_lane0..3 (16 bits each, lowest first)
    output logic [63:0]       m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    import fgsa_pkg::*;

    logic [FP_W-1:0] alpha_reg;
    logic [FP_W-1:0] beta_reg;
    logic [FP_W-1:0] inner_reg;
    logic [FP_W-1:0] step_reg;
    logic [FP_W-1:0] step_next;
    logic [FP_W-1:0] step_inc;
    logic            s1_valid_reg;
    logic            s1_scale_reg;
    logic            out_valid_reg;
    logic            out_load;
    logic            fire;
    logic            scale_only;
    logic            emit;
    lane_ctl_t       ctl;
    logic [FP_W-1:0] lane_out [NUM_LANES];

    assign cfg_ready  = 1'b1;
    assign out_load   = !out_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || out_load;
    assign fire       = s_tvalid && s_tready;
    assign scale_only = inner_reg == 16'd0;
    assign step_inc   = step_reg + 16'd1;
    assign emit       = scale_only || (step_inc >= inner_reg);

    always_comb
    begin
        step_next = step_reg;
        if (fire && !scale_only)
        begin
            step_next = emit ? 16'd0 : step_inc;
        end
    end

    assign ctl.acc_we        = fire && !scale_only;
    assign ctl.first         = step_reg == 16'd0;
    assign ctl.s1_load       = fire;
    assign ctl.s2_load       = out_load && s1_valid_reg;
    assign ctl.s2_scale_only = s1_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= ALPHA_RST;
            beta_reg      <= 16'd0;
            inner_reg     <= 16'd1;
            step_reg      <= 16'd0;
            s1_valid_reg  <= 1'b0;
            s1_scale_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_ALPHA: alpha_reg <= cfg_data;
                    REG_BETA:  beta_reg  <= cfg_data;
                    REG_INNER: inner_reg <= cfg_data;
                    default:   ;
                endcase
            end
            step_reg <= step_next;
            if (s_tready)
            begin
                s1_valid_reg <= fire && emit;
                s1_scale_reg <= scale_only;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        if (l < LANES)
        begin : g_used
            fgsa_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .a_value    (s_tdata[15:0]),
                .b_value    (s_tdata[16*(l+1) +: 16]),
                .c_old      (s_tdata[16*(l+5) +: 16]),
                .alpha_bits (alpha_reg),
                .beta_bits  (beta_reg),
                .c_new      (lane_out[l])
            );
        end
        else
        begin : g_unused
            assign lane_out[l] = 16'd0;
        end
        assign m_tdata[16*l +: 16] = lane_out[l];
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire
